/* sv/gcdlcm_pkg.sv */
`default_nettype none

package gcdlcm_pkg;

   localparam int unsigned FIELD_WIDTH           = 32;
   localparam int unsigned MULTIPLE_WIDTH        = 2 * FIELD_WIDTH;
   localparam int unsigned OPERAND_WIDTH_DEFAULT = 32;

endpackage : gcdlcm_pkg

`default_nettype wire

/* sv/gcd_and_lcm_top.sv */
// Each division runs on the shared restoring divider; an item takes one division per
// Euclid remainder step (at most 46 at 32 bits), one for a / gcd, then a shift-and-add
// multiply into the result beat; when both operands are zero no division is run.
// Throughput: one item at a time; busy stays high until the result strobe is raised.
// The receiver cannot stall: rsp_valid is high for exactly one cycle per item.
// Reset: synchronous, active high; returns to idle and drops any item at work.
`default_nettype none

module gcd_and_lcm_top #(
   parameter int unsigned OPERAND_WIDTH = gcdlcm_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [gcdlcm_pkg::FIELD_WIDTH-1:0]    req_first_operand,
   input  wire logic [gcdlcm_pkg::FIELD_WIDTH-1:0]    req_second_operand,
   output logic                                       rsp_valid,
   output logic [gcdlcm_pkg::FIELD_WIDTH-1:0]         rsp_divisor,
   output logic [gcdlcm_pkg::MULTIPLE_WIDTH-1:0]      rsp_multiple
);

   localparam int unsigned W     = OPERAND_WIDTH;
   localparam int unsigned CNT_W = $clog2(W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EUCLID,
      ST_DIVQ,
      ST_MUL
   } state_type;

   state_type        state_ff;
   logic [W-1:0]     a_ff, b_ff;
   logic [W-1:0]     x_ff, y_ff;
   logic [W-1:0]     g_ff;
   logic [2*W-1:0]   mcand_ff;
   logic [W-1:0]     mplier_ff;
   logic [2*W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             valid_ff;

   logic             div_start;
   logic [W-1:0]     div_dividend;
   logic [W-1:0]     div_divisor;
   logic             div_done;
   logic [W-1:0]     div_quotient;
   logic [W-1:0]     div_remainder;

   logic             accept;

   assign accept = start && (state_ff == ST_IDLE);

   // a Euclid step while y is non-zero, otherwise a / gcd unless the gcd is zero
   always_comb begin
      div_start    = 1'b0;
      div_dividend = x_ff;
      div_divisor  = y_ff;
      if (state_ff == ST_CHECK) begin
         if (y_ff != '0) begin
            div_start = 1'b1;
         end else begin
            div_start    = (x_ff != '0);
            div_dividend = a_ff;
            div_divisor  = x_ff;
         end
      end
   end

   assign acc_in = acc_ff + (mplier_ff[0] ? mcand_ff : '0);

   gcdlcm_div #(
      .OPERAND_WIDTH(W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient),
      .remainder(div_remainder)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  a_ff     <= req_first_operand[W-1:0];
                  b_ff     <= req_second_operand[W-1:0];
                  x_ff     <= req_first_operand[W-1:0];
                  y_ff     <= req_second_operand[W-1:0];
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (y_ff != '0) begin
                  state_ff <= ST_EUCLID;
               end else if (x_ff != '0) begin
                  g_ff     <= x_ff;
                  state_ff <= ST_DIVQ;
               end else begin
                  // both operands zero: no division
                  g_ff     <= '0;
                  acc_ff   <= '0;
                  valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            ST_EUCLID: begin
               if (div_done) begin
                  x_ff     <= y_ff;
                  y_ff     <= div_remainder;
                  state_ff <= ST_CHECK;
               end
            end
            ST_DIVQ: begin
               if (div_done) begin
                  mcand_ff  <= {{W{1'b0}}, div_quotient};
                  mplier_ff <= b_ff;
                  acc_ff    <= '0;
                  cnt_ff    <= '0;
                  state_ff  <= ST_MUL;
               end
            end
            ST_MUL: begin
               acc_ff    <= acc_in;
               mcand_ff  <= {mcand_ff[2*W-2:0], 1'b0};
               mplier_ff <= {1'b0, mplier_ff[W-1:1]};
               cnt_ff    <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(W - 1)) begin
                  valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      rsp_divisor         = '0;
      rsp_divisor[W-1:0]  = g_ff;
      rsp_multiple        = '0;
      rsp_multiple[2*W-1:0] = acc_ff;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted beat");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_zero_gcd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_divisor == '0)) |-> (rsp_multiple == '0))
      else $error("non-zero multiple with zero divisor");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == ST_EUCLID) || (state_ff == ST_DIVQ)))
      else $error("divider finished outside a division state");

endmodule : gcd_and_lcm_top

`default_nettype wire

/* sv/gcdlcm_div.sv */
`default_nettype none

module gcdlcm_div #(
   parameter int unsigned OPERAND_WIDTH = gcdlcm_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [OPERAND_WIDTH-1:0] dividend,
   input  wire logic [OPERAND_WIDTH-1:0] divisor,
   output logic                          done,
   output logic [OPERAND_WIDTH-1:0]      quotient,
   output logic [OPERAND_WIDTH-1:0]      remainder
);

   localparam int unsigned CNT_W = $clog2(OPERAND_WIDTH);

   logic [OPERAND_WIDTH-1:0] rem_ff, rem_in;
   logic [OPERAND_WIDTH-1:0] quo_ff, quo_in;
   logic [OPERAND_WIDTH-1:0] dvs_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     run_ff;
   logic                     done_ff;

   logic [OPERAND_WIDTH:0]   trial;
   logic [OPERAND_WIDTH:0]   diff;
   logic                     fits;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff, quo_ff[OPERAND_WIDTH-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = (trial >= {1'b0, dvs_ff});
      rem_in = fits ? diff[OPERAND_WIDTH-1:0] : trial[OPERAND_WIDTH-1:0];
      quo_in = {quo_ff[OPERAND_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff <= '0;
            quo_ff <= dividend;
            dvs_ff <= divisor;
            cnt_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(OPERAND_WIDTH - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule : gcdlcm_div

`default_nettype wire

/* bench/tb_gcd_and_lcm_top.sv */
module tb_gcd_and_lcm_top;

   localparam int unsigned OPW          = gcdlcm_pkg::OPERAND_WIDTH_DEFAULT;
   localparam int unsigned FW           = gcdlcm_pkg::FIELD_WIDTH;
   localparam int unsigned MW           = gcdlcm_pkg::MULTIPLE_WIDTH;
   localparam logic [63:0] OPERAND_MASK = (64'd1 << OPW) - 64'd1;
   localparam int unsigned CYCLE_LIMIT  = 10_000_000;
   // Worst case: 46 Euclid divisions and one for a / gcd, then the multiply; the figure
   // below leaves some margin on top
   localparam int unsigned SETTLE_CYCLES = 50 * (OPW + 2) + 2 * OPW;

   typedef struct packed {
      logic [FW-1:0] first;
      logic [FW-1:0] second;
   } operand_pair_type;

   typedef struct packed {
      logic [FW-1:0] divisor;
      logic [MW-1:0] multiple;
   } gcd_lcm_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   logic [FW-1:0] req_first_operand  = '0;
   logic [FW-1:0] req_second_operand = '0;
   logic          rsp_valid;
   logic [FW-1:0] rsp_divisor;
   logic [MW-1:0] rsp_multiple;

   operand_pair_type pending_pairs[$];
   gcd_lcm_type      expected_results[$];
   operand_pair_type held_pair;

   int unsigned sender_gap_pct  = 22;
   int unsigned pairs_queued    = 0;
   int unsigned pairs_accepted  = 0;
   int unsigned results_checked = 0;
   int unsigned zero_pairs      = 0;
   int unsigned shared_factor   = 0;
   int unsigned mismatch_count  = 0;
   int unsigned cycle_count     = 0;

   gcd_and_lcm_top dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_first_operand  (req_first_operand),
      .req_second_operand (req_second_operand),
      .rsp_valid          (rsp_valid),
      .rsp_divisor        (rsp_divisor),
      .rsp_multiple       (rsp_multiple)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Euclid on the masked operands; the multiple is (a / gcd) * b at double width
   function automatic gcd_lcm_type predict_gcd_lcm(input operand_pair_type pair);
      logic [63:0] a, b, x, y, rem;
      gcd_lcm_type res;
      a = {32'd0, pair.first} & OPERAND_MASK;
      b = {32'd0, pair.second} & OPERAND_MASK;
      x = a;
      y = b;
      while (y != 64'd0) begin
         rem = x % y;
         x   = y;
         y   = rem;
      end
      res.divisor  = x[FW-1:0];
      res.multiple = (x != 64'd0) ? (a / x) * b : 64'd0;
      return res;
   endfunction

   function automatic logic [31:0] edge_value();
      case ($urandom_range(3))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic operand_pair_type random_pair();
      int unsigned      kind, g, n, i;
      logic [31:0]      f0, f1, f2, tmp;
      operand_pair_type p;
      kind = $urandom_range(99);
      if (kind < 30) begin
         p.first  = $urandom;
         p.second = $urandom;
      end else if (kind < 55) begin
         // common factor, cofactors kept to 16 bits so nothing wraps
         g        = $urandom_range(65535, 1) >> $urandom_range(15);
         p.first  = g * ($urandom >> $urandom_range(31, 16));
         p.second = g * ($urandom >> $urandom_range(31, 16));
      end else if (kind < 70) begin
         p.first  = $urandom >> $urandom_range(31);
         p.second = $urandom >> $urandom_range(31);
      end else if (kind < 78) begin
         // adjacent Fibonacci numbers: the longest remainder chains
         n  = $urandom_range(46, 1);
         f0 = 32'd0;
         f1 = 32'd1;
         for (i = 0; i < n; i++) begin
            f2 = f0 + f1;
            f0 = f1;
            f1 = f2;
         end
         p.first  = f1;
         p.second = f0;
      end else if (kind < 86) begin
         p.first  = $urandom >> $urandom_range(31, 8);
         p.second = p.first * $urandom_range(255, 1);
      end else if (kind < 91) begin
         p.first  = $urandom >> $urandom_range(31);
         p.second = p.first;
      end else begin
         p.first  = edge_value();
         p.second = edge_value();
      end
      if ($urandom_range(1)) begin
         tmp      = p.first;
         p.first  = p.second;
         p.second = tmp;
      end
      return p;
   endfunction

   task automatic queue_pair(input logic [31:0] a, input logic [31:0] b);
      operand_pair_type p;
      p.first  = a;
      p.second = b;
      pending_pairs.push_back(p);
      pairs_queued++;
   endtask

   // hold until every queued beat is in and every result is out
   task automatic drain_all();
      while (pairs_accepted != pairs_queued || expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic flag_mismatch(input string field, input logic [63:0] got,
                                input logic [63:0] want);
      mismatch_count++;
      $display("[%0d] %s mismatch: got 0x%0h, want 0x%0h", cycle_count, field, got, want);
   endtask

   // Driver: one nonblocking write to start per edge
   always @(posedge clock) begin
      logic        next_start;
      gcd_lcm_type want;
      if (reset) begin
         start <= 1'b0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            want = predict_gcd_lcm(held_pair);
            expected_results.push_back(want);
            pairs_accepted++;
            if (held_pair.first == '0 || held_pair.second == '0)
               zero_pairs++;
            if (want.divisor > 1)
               shared_factor++;
            next_start = 1'b0;
         end
         if (!next_start && pending_pairs.size() != 0
             && $urandom_range(99) >= sender_gap_pct) begin
            held_pair          = pending_pairs.pop_front();
            req_first_operand  <= held_pair.first;
            req_second_operand <= held_pair.second;
            next_start         = 1'b1;
         end
         start <= next_start;
      end
   end

   // Monitor: each strobe takes the oldest expectation
   always @(posedge clock) begin
      gcd_lcm_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            flag_mismatch("unrequested result", {32'd0, rsp_divisor}, 64'd0);
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (rsp_divisor !== want.divisor)
               flag_mismatch("divisor", {32'd0, rsp_divisor}, {32'd0, want.divisor});
            if (rsp_multiple !== want.multiple)
               flag_mismatch("multiple", rsp_multiple, want.multiple);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out at cycle %0d with %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned gap_pct[3];
      int unsigned beats[3];
      int unsigned ph, k;
      gap_pct = '{22, 61, 0};
      beats   = '{480, 480, 490};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // zero operands, extremes, alternating bits, longest chain, coprime giants
      queue_pair(32'd0, 32'd0);
      queue_pair(32'd0, 32'd5);
      queue_pair(32'd7, 32'd0);
      queue_pair(32'd0, 32'hFFFF_FFFF);
      queue_pair(32'hFFFF_FFFF, 32'd0);
      queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      queue_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      queue_pair(32'd1, 32'd1);
      queue_pair(32'd1, 32'hFFFF_FFFF);
      queue_pair(32'd12, 32'd18);
      queue_pair(32'd18, 32'd12);
      queue_pair(32'd2971215073, 32'd1836311903);
      queue_pair(32'd1836311903, 32'd2971215073);
      queue_pair(32'h8000_0000, 32'h4000_0000);
      queue_pair(32'hAAAA_AAAA, 32'h5555_5555);
      queue_pair(32'h5555_5555, 32'hAAAA_AAAA);
      queue_pair(32'd4294967291, 32'hFFFF_FFFF);
      queue_pair(32'd3, 32'hFFFF_FFFF);
      queue_pair(32'd65536, 32'd65536);
      queue_pair(32'd4294967291, 32'd4294967279);
      drain_all();

      for (ph = 0; ph < 3; ph++) begin
         sender_gap_pct = gap_pct[ph];
         for (k = 0; k < beats[ph]; k++) begin
            pending_pairs.push_back(random_pair());
            pairs_queued++;
         end
         drain_all();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d gcd/lcm results from %0d operand pairs in %0d cycles",
               results_checked, pairs_accepted, cycle_count);
      $display("  %0d pairs had a zero operand, %0d shared a factor above one",
               zero_pairs, shared_factor);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  mismatch_count, expected_results.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
